/* src/assert_macros.svh */
// Assertion shorthands shared by the RTL. All checks are clocked on the
// rising edge and are off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante at an edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bdpc_pkg.sv */
`default_nettype none

package bdpc_pkg;

    // width of the internal time base; input timestamps are cut or
    // zero-extended to it, differences wrap at this width
    localparam int TIME_BITS    = 32;
    localparam int IN_TIME_BITS = 32;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 8;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CFG_BITS-1:0]  t_cfg_val;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DEBOUNCE  = 8'd0,
        REG_MIN_PRESS = 8'd1,
        REG_MAX_SHORT = 8'd2,
        REG_LONG      = 8'd3
    } t_cfg_idx;

    localparam t_cfg_val DEBOUNCE_RST  = 16'd25;
    localparam t_cfg_val MIN_PRESS_RST = 16'd30;
    localparam t_cfg_val MAX_SHORT_RST = 16'd1200;
    localparam t_cfg_val LONG_RST      = 16'd1800;

    typedef struct packed {
        t_cfg_val debounce_ms;
        t_cfg_val min_press_ms;
        t_cfg_val max_short_ms;
        t_cfg_val long_press_ms;
    } t_cfg;

    typedef struct packed {
        t_time now;
        logic  level;
        logic  take_short;
        logic  take_long;
    } t_item;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic stable_level;
    } t_result;

endpackage

`default_nettype wire

/* src/bdpc_classifier.sv */
`default_nettype none
`include "assert_macros.svh"

module bdpc_classifier (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire bdpc_pkg::t_item  i_item,
    input  wire bdpc_pkg::t_cfg   i_cfg,
    output bdpc_pkg::t_result     o_result
);

    logic            r_started,        n_started;
    logic            r_raw,            n_raw;
    logic            r_stable,         n_stable;
    logic            r_short_pending,  n_short_pending;
    logic            r_long_pending,   n_long_pending;
    logic            r_long_fired,     n_long_fired;
    bdpc_pkg::t_time r_change_time,    n_change_time;
    bdpc_pkg::t_time r_press_start,    n_press_start;

    bdpc_pkg::t_time w_since_change;
    bdpc_pkg::t_time w_held;
    logic            w_short_upd;
    logic            w_long_upd;

    always_comb begin
        n_started       = r_started;
        n_raw           = r_raw;
        n_stable        = r_stable;
        n_short_pending = r_short_pending;
        n_long_pending  = r_long_pending;
        n_long_fired    = r_long_fired;
        n_change_time   = r_change_time;
        n_press_start   = r_press_start;
        w_since_change  = '0;
        w_held          = i_item.now - r_press_start;

        if (!r_started) begin
            // first item only seeds the state
            n_started       = 1'b1;
            n_raw           = i_item.level;
            n_stable        = i_item.level;
            n_change_time   = i_item.now;
            n_press_start   = i_item.now;
            n_short_pending = 1'b0;
            n_long_pending  = 1'b0;
            n_long_fired    = 1'b0;
        end else begin
            n_raw = i_item.level;
            if (i_item.level != r_raw) begin
                n_change_time = i_item.now;
            end
            w_since_change = i_item.now - n_change_time;
            if (w_since_change >= bdpc_pkg::t_time'(i_cfg.debounce_ms)) begin
                if (r_stable == n_raw) begin
                    if (r_stable && !r_long_fired &&
                        w_held >= bdpc_pkg::t_time'(i_cfg.long_press_ms)) begin
                        n_long_pending = 1'b1;
                        n_long_fired   = 1'b1;
                    end
                end else begin
                    n_stable = n_raw;
                    if (n_raw) begin
                        n_press_start = i_item.now;
                        n_long_fired  = 1'b0;
                    end else if (!r_long_fired &&
                                 w_held >= bdpc_pkg::t_time'(i_cfg.min_press_ms) &&
                                 w_held <= bdpc_pkg::t_time'(i_cfg.max_short_ms)) begin
                        n_short_pending = 1'b1;
                    end
                end
            end
        end

        // take requests see the updated flags and clear them
        w_short_upd = n_short_pending;
        w_long_upd  = n_long_pending;
        o_result.short_press  = i_item.take_short & w_short_upd;
        o_result.long_press   = i_item.take_long & w_long_upd;
        o_result.stable_level = n_stable;
        if (i_item.take_short) begin
            n_short_pending = 1'b0;
        end
        if (i_item.take_long) begin
            n_long_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started       <= 1'b0;
            r_raw           <= 1'b0;
            r_stable        <= 1'b0;
            r_short_pending <= 1'b0;
            r_long_pending  <= 1'b0;
            r_long_fired    <= 1'b0;
            r_change_time   <= '0;
            r_press_start   <= '0;
        end else if (i_adv) begin
            r_started       <= n_started;
            r_raw           <= n_raw;
            r_stable        <= n_stable;
            r_short_pending <= n_short_pending;
            r_long_pending  <= n_long_pending;
            r_long_fired    <= n_long_fired;
            r_change_time   <= n_change_time;
            r_press_start   <= n_press_start;
        end
    end

    `ASSERT_NEXT(a_started_after_item, i_clk, i_rst_n, i_adv, r_started,
        "classifier not started after an item")
    `ASSERT_NEXT(a_idle_holds_state, i_clk, i_rst_n, !i_adv,
        $stable(r_change_time) && $stable(r_press_start) && $stable(r_stable),
        "classifier state moved without an item")
    `ASSERT_NEXT(a_pending_needs_start, i_clk, i_rst_n, 1'b1,
        !(r_long_pending || r_short_pending) || r_started,
        "event pending before first item")

endmodule

`default_nettype wire

/* src/button_debounce_press_classifier.sv */
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+----------------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_time_ms, i_level_pressed,
//          |           |                            | i_take_short, i_take_long
// out      | output    | o_out_valid / i_out_ready  | o_short_press, o_long_press,
//          |           |                            | o_stable_level
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Each item passes through the input register and then the result register;
// one item per cycle is sustained while results are accepted on the output.
// The state update (wrapping time differences and threshold compares) is a
// single pass of logic between the input register and the result register.
// An unread result only stalls the input side once the input register is
// also full; otherwise a new item is taken while the result waits.
// Reset (synchronous, active low) clears the pipeline, the classifier state
// and loads the default thresholds 25 / 30 / 1200 / 1800 ms.
// Config writes are always accepted; indexes past the last register are dropped.
`default_nettype none
`include "assert_macros.svh"

module button_debounce_press_classifier (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // poll items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [bdpc_pkg::IN_TIME_BITS-1:0] i_time_ms,
    input  wire logic                              i_level_pressed,
    input  wire logic                              i_take_short,
    input  wire logic                              i_take_long,
    // results
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_short_press,
    output logic                                   o_long_press,
    output logic                                   o_stable_level,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bdpc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [bdpc_pkg::CFG_BITS-1:0]     i_cfg_data
);

    // threshold registers
    bdpc_pkg::t_cfg    r_cfg;

    // input stage
    logic              r_in_vld;
    bdpc_pkg::t_item   r_item;

    // result stage
    logic              r_out_vld;
    bdpc_pkg::t_result r_result;

    bdpc_pkg::t_result w_result;
    logic              w_adv;
    logic              w_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bdpc_pkg::DEBOUNCE_RST;
            r_cfg.min_press_ms  <= bdpc_pkg::MIN_PRESS_RST;
            r_cfg.max_short_ms  <= bdpc_pkg::MAX_SHORT_RST;
            r_cfg.long_press_ms <= bdpc_pkg::LONG_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bdpc_pkg::REG_DEBOUNCE:  r_cfg.debounce_ms   <= i_cfg_data;
                bdpc_pkg::REG_MIN_PRESS: r_cfg.min_press_ms  <= i_cfg_data;
                bdpc_pkg::REG_MAX_SHORT: r_cfg.max_short_ms  <= i_cfg_data;
                bdpc_pkg::REG_LONG:      r_cfg.long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the item in the input register moves on when the result slot is
    // free or being emptied this cycle
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_take || (r_in_vld && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.now        <= bdpc_pkg::t_time'(i_time_ms);
            r_item.level      <= i_level_pressed;
            r_item.take_short <= i_take_short;
            r_item.take_long  <= i_take_long;
        end
    end

    bdpc_classifier u_classifier (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_adv || (r_out_vld && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_short_press  = r_result.short_press;
    assign o_long_press   = r_result.long_press;
    assign o_stable_level = r_result.stable_level;

    `ASSERT_NEXT(a_held_result_blocks, i_clk, i_rst_n, 1'b1,
        !(r_out_vld && !i_out_ready) || !w_adv,
        "item advanced into an occupied result register")
    `ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, w_adv, r_out_vld,
        "advanced item produced no result")
    `ASSERT_NEXT(a_full_input_stall, i_clk, i_rst_n,
        r_in_vld && r_out_vld && !i_out_ready, r_in_vld,
        "stalled item dropped from the input register")

endmodule

`default_nettype wire
